// ===== rtl/core/tnspp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spectral peak picker package
// Field widths, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
package tnspp_pkg;

   localparam int MAG_W       = 32;
   localparam int PEAK_BIN_W  = 12;
   localparam int MIN_BIN_W   = 12;
   localparam int MAX_BIN_W   = 13;
   localparam int NUM_PEAKS_W = 6;
   localparam int MARGIN_W    = 13;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 13;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_BIN     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BIN     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_PEAKS   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MARGIN_BINS = 3'd3;

   // register reset values
   localparam logic [MIN_BIN_W-1:0]   MIN_BIN_RST   = 12'd0;
   localparam logic [MAX_BIN_W-1:0]   MAX_BIN_RST   = 13'd4096;
   localparam logic [NUM_PEAKS_W-1:0] NUM_PEAKS_RST = 6'd4;
   localparam logic [MARGIN_W-1:0]    MARGIN_RST    = 13'd1;

   typedef struct packed {
      logic [MIN_BIN_W-1:0]   min_bin;
      logic [MAX_BIN_W-1:0]   max_bin;
      logic [NUM_PEAKS_W-1:0] num_peaks;
      logic [MARGIN_W-1:0]    margin_bins;
   } cfg_type;

   typedef struct packed {
      logic [PEAK_BIN_W-1:0] peak_bin;
      logic [MAG_W-1:0]      peak_magnitude;
      logic                  last_peak;
   } rsp_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_START,
      BK_SCAN,
      BK_EMIT,
      BK_FINISH
   } back_state_type;

endpackage

// ===== rtl/core/tnspp_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Short register queue
// Small first-in first-out buffer; DEPTH must be a power of two, at least 2.
// ----------------------------------------------------------------------------
module tnspp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push_ok, pop_ok;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign push_ok  = push && !full;
   assign pop_ok   = pop && !empty;
   assign pop_data = data_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push_ok) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop_ok) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/tnspp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peak picker front end
// Accepts bins, writes them to the store and queues a search job on the
// last-bin mark.
// ----------------------------------------------------------------------------
module tnspp_front #(
   parameter int MAX_BINS = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [tnspp_pkg::MAX_BIN_W-1:0] max_bin,
   input  logic                            push,
   input  logic [tnspp_pkg::MAG_W-1:0]     magnitude,
   input  logic                            last_bin,
   output logic                            full,
   output logic                            wr_en,
   output logic [$clog2(MAX_BINS)-1:0]     wr_addr,
   output logic [tnspp_pkg::MAG_W-1:0]     wr_data,
   output logic                            job_push,
   output logic [((($clog2(MAX_BINS+1)) > tnspp_pkg::MAX_BIN_W) ?
                  $clog2(MAX_BINS+1) : tnspp_pkg::MAX_BIN_W)-1:0] job_hi,
   input  logic                            job_full,
   input  logic                            done
);

   localparam int BIN_W = $clog2(MAX_BINS);
   localparam int CNT_W = $clog2(MAX_BINS + 1);
   localparam int CMP_W = (CNT_W > tnspp_pkg::MAX_BIN_W) ? CNT_W : tnspp_pkg::MAX_BIN_W;

   logic [CNT_W-1:0] count_ff, count_in, loaded;
   logic [CMP_W-1:0] max_ext, loaded_ext;
   logic             busy_ff, busy_in;
   logic             accept, store_ok;

   assign full     = busy_ff || job_full;
   assign accept   = push && !full;
   assign store_ok = (count_ff < CNT_W'(MAX_BINS));

   // drop bins once the store is full
   assign wr_en   = accept && store_ok;
   assign wr_addr = count_ff[BIN_W-1:0];
   assign wr_data = magnitude;

   assign loaded     = store_ok ? (count_ff + 1'b1) : count_ff;
   assign max_ext    = CMP_W'(max_bin);
   assign loaded_ext = CMP_W'(loaded);

   assign job_push = accept && last_bin;
   assign job_hi   = (max_ext < loaded_ext) ? max_ext : loaded_ext;

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         count_in = last_bin ? '0 : loaded;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      if (job_push) begin
         busy_in = 1'b1;
      end else if (done) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
      end
   end

endmodule

// ===== rtl/core/tnspp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peak picker search engine
// Holds the bin store and runs the exclusion-aware maximum search, one
// bin per cycle and one pass per pick.
// ----------------------------------------------------------------------------
module tnspp_back #(
   parameter int MAX_BINS  = 4096,
   parameter int MAX_PEAKS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  tnspp_pkg::cfg_type          cfg,
   input  logic                        wr_en,
   input  logic [$clog2(MAX_BINS)-1:0] wr_addr,
   input  logic [tnspp_pkg::MAG_W-1:0] wr_data,
   input  logic                        job_valid,
   input  logic [((($clog2(MAX_BINS+1)) > tnspp_pkg::MAX_BIN_W) ?
                  $clog2(MAX_BINS+1) : tnspp_pkg::MAX_BIN_W)-1:0] job_hi,
   output logic                        job_pop,
   output logic                        rsp_push,
   output tnspp_pkg::rsp_type          rsp_data,
   input  logic                        rsp_full,
   output logic                        done
);

   localparam int BIN_W    = $clog2(MAX_BINS);
   localparam int CNT_W    = $clog2(MAX_BINS + 1);
   localparam int CMP_W    = (CNT_W > tnspp_pkg::MAX_BIN_W) ? CNT_W : tnspp_pkg::MAX_BIN_W;
   localparam int PASS_W   = $clog2(MAX_PEAKS + 1);
   localparam int PK_IDX_W = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;
   localparam int NPK_W    = tnspp_pkg::NUM_PEAKS_W + 1;

   tnspp_pkg::back_state_type state_ff, state_in;

   logic [tnspp_pkg::MAG_W-1:0]      bin_mem_ff [MAX_BINS];
   logic [tnspp_pkg::PEAK_BIN_W-1:0] picks_ff [MAX_PEAKS];

   logic [CMP_W-1:0]                 hi_ff, addr_ff, s1_bin_ff;
   logic [PASS_W-1:0]                npk_ff, pass_ff, npk_sat;
   logic                             s1_valid_ff, s1_excl_ff;
   logic [tnspp_pkg::MAG_W-1:0]      rdata_ff, best_ff;
   logic [tnspp_pkg::PEAK_BIN_W-1:0] best_bin_ff;
   logic                             init_pass, issue, emit, in_range, excl, last_pass;

   assign npk_sat = (NPK_W'(cfg.num_peaks) > NPK_W'(MAX_PEAKS)) ?
                    PASS_W'(MAX_PEAKS) : PASS_W'(cfg.num_peaks);
   assign in_range  = (addr_ff < hi_ff);
   assign last_pass = (PASS_W'(pass_ff + 1'b1) == npk_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tnspp_pkg::BK_IDLE: begin
            if (job_valid) begin
               state_in = (npk_sat == '0) ? tnspp_pkg::BK_FINISH : tnspp_pkg::BK_START;
            end
         end
         tnspp_pkg::BK_START: begin
            state_in = tnspp_pkg::BK_SCAN;
         end
         tnspp_pkg::BK_SCAN: begin
            if (!in_range) begin
               state_in = tnspp_pkg::BK_EMIT;
            end
         end
         tnspp_pkg::BK_EMIT: begin
            if (!rsp_full) begin
               state_in = last_pass ? tnspp_pkg::BK_FINISH : tnspp_pkg::BK_START;
            end
         end
         tnspp_pkg::BK_FINISH: begin
            state_in = tnspp_pkg::BK_IDLE;
         end
         default: begin
            state_in = tnspp_pkg::BK_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      job_pop   = 1'b0;
      init_pass = 1'b0;
      issue     = 1'b0;
      emit      = 1'b0;
      done      = 1'b0;
      case (state_ff)
         tnspp_pkg::BK_IDLE:   job_pop   = job_valid;
         tnspp_pkg::BK_START:  init_pass = 1'b1;
         tnspp_pkg::BK_SCAN:   issue     = in_range;
         tnspp_pkg::BK_EMIT:   emit      = !rsp_full;
         tnspp_pkg::BK_FINISH: done      = 1'b1;
         default: begin
         end
      endcase
   end

   // exclusion against picks of earlier passes
   always_comb begin
      logic [CMP_W-1:0] pick_ext;
      logic [CMP_W-1:0] gap;
      excl = 1'b0;
      for (int i = 0; i < MAX_PEAKS; i++) begin
         pick_ext = CMP_W'(picks_ff[i]);
         gap      = (addr_ff > pick_ext) ? (addr_ff - pick_ext) : (pick_ext - addr_ff);
         if ((PASS_W'(i) < pass_ff) && (gap < CMP_W'(cfg.margin_bins))) begin
            excl = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= tnspp_pkg::BK_IDLE;
         s1_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         s1_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         hi_ff   <= job_hi;
         npk_ff  <= npk_sat;
         pass_ff <= '0;
      end
      if (init_pass) begin
         addr_ff     <= CMP_W'(cfg.min_bin);
         best_ff     <= '0;
         best_bin_ff <= '0;
      end
      if (issue) begin
         addr_ff    <= addr_ff + 1'b1;
         s1_bin_ff  <= addr_ff;
         s1_excl_ff <= excl;
      end
      // strictly greater wins, so ties keep the lower bin
      if (s1_valid_ff && !s1_excl_ff && (rdata_ff > best_ff)) begin
         best_ff     <= rdata_ff;
         best_bin_ff <= s1_bin_ff[tnspp_pkg::PEAK_BIN_W-1:0];
      end
      if (emit) begin
         picks_ff[pass_ff[PK_IDX_W-1:0]] <= best_bin_ff;
         pass_ff <= pass_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bin_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rdata_ff <= bin_mem_ff[addr_ff[BIN_W-1:0]];
      end
   end

   assign rsp_push                = emit;
   assign rsp_data.peak_bin       = best_bin_ff;
   assign rsp_data.peak_magnitude = best_ff;
   assign rsp_data.last_peak      = last_pass;

endmodule

// ===== rtl/core/top_n_spectral_peak_picker_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Top-N spectral peak picker
// Stores a spectrum one bin per cycle, then picks the strongest bins in
// turn, skipping any bin within the margin of an earlier pick.
// ----------------------------------------------------------------------------
// Throughput: one bin accepted per cycle while loading a spectrum.
// Search: each pick is one pass from min_bin up to min(max_bin, bins), exclusive,
//   read through the single read port of the bin store (one bin per cycle).
// First pick: the job passes the job queue, then the engine's start, scan and emit states.
// req_full stays high from the last bin until the engine has queued the final pick and finished.
// Reset (synchronous): registers to defaults, queues empty, bin count zero;
//   the bin store is not cleared.
// ----------------------------------------------------------------------------
module top_n_spectral_peak_picker_core #(
   parameter int MAX_BINS  = 4096,
   parameter int MAX_PEAKS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   // bin input
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [tnspp_pkg::MAG_W-1:0]         req_magnitude,
   input  logic                                req_last_bin,
   // pick output
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic [tnspp_pkg::PEAK_BIN_W-1:0]    rsp_peak_bin,
   output logic [tnspp_pkg::MAG_W-1:0]         rsp_peak_magnitude,
   output logic                                rsp_last_peak,
   // register writes
   input  logic                                csr_we,
   input  logic [tnspp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tnspp_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int BIN_W = $clog2(MAX_BINS);
   localparam int CNT_W = $clog2(MAX_BINS + 1);
   localparam int CMP_W = (CNT_W > tnspp_pkg::MAX_BIN_W) ? CNT_W : tnspp_pkg::MAX_BIN_W;

   tnspp_pkg::cfg_type cfg_ff;
   tnspp_pkg::rsp_type rsp_push_data, rsp_pop_data;

   logic                        wr_en;
   logic [BIN_W-1:0]            wr_addr;
   logic [tnspp_pkg::MAG_W-1:0] wr_data;
   logic                        job_push, job_full, job_pop, job_empty, done;
   logic [CMP_W-1:0]            job_hi_push, job_hi_pop;
   logic                        rsp_push, rsp_full;

   // configuration registers; indexes beyond the list are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_bin     <= tnspp_pkg::MIN_BIN_RST;
         cfg_ff.max_bin     <= tnspp_pkg::MAX_BIN_RST;
         cfg_ff.num_peaks   <= tnspp_pkg::NUM_PEAKS_RST;
         cfg_ff.margin_bins <= tnspp_pkg::MARGIN_RST;
      end else if (csr_we) begin
         case (csr_index)
            tnspp_pkg::CSR_MIN_BIN:
               cfg_ff.min_bin <= csr_wdata[tnspp_pkg::MIN_BIN_W-1:0];
            tnspp_pkg::CSR_MAX_BIN:
               cfg_ff.max_bin <= csr_wdata[tnspp_pkg::MAX_BIN_W-1:0];
            tnspp_pkg::CSR_NUM_PEAKS:
               cfg_ff.num_peaks <= csr_wdata[tnspp_pkg::NUM_PEAKS_W-1:0];
            tnspp_pkg::CSR_MARGIN_BINS:
               cfg_ff.margin_bins <= csr_wdata[tnspp_pkg::MARGIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // front: take bins, fill the store, raise a job on the last bin
   tnspp_front #(
      .MAX_BINS (MAX_BINS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .max_bin   (cfg_ff.max_bin),
      .push      (req_push),
      .magnitude (req_magnitude),
      .last_bin  (req_last_bin),
      .full      (req_full),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .job_push  (job_push),
      .job_hi    (job_hi_push),
      .job_full  (job_full),
      .done      (done)
   );

   // job queue: carries the clipped search bound to the engine
   tnspp_fifo #(
      .WIDTH (CMP_W),
      .DEPTH (2)
   ) u_job_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_hi_push),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (job_hi_pop),
      .empty     (job_empty)
   );

   // back: one pass per pick over the stored bins
   tnspp_back #(
      .MAX_BINS  (MAX_BINS),
      .MAX_PEAKS (MAX_PEAKS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .job_valid (!job_empty),
      .job_hi    (job_hi_pop),
      .job_pop   (job_pop),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_push_data),
      .rsp_full  (rsp_full),
      .done      (done)
   );

   // result queue: hold picks until the consumer pops them
   tnspp_fifo #(
      .WIDTH ($bits(tnspp_pkg::rsp_type)),
      .DEPTH (2)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_push_data),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_pop_data),
      .empty     (rsp_empty)
   );

   assign rsp_peak_bin       = rsp_pop_data.peak_bin;
   assign rsp_peak_magnitude = rsp_pop_data.peak_magnitude;
   assign rsp_last_peak      = rsp_pop_data.last_peak;

endmodule

// ===== rtl/core/tnspp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peak picker port checker
// Watches the top-level ports for queue and search-run consistency.
// ----------------------------------------------------------------------------
module tnspp_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_push,
   input logic                             req_full,
   input logic                             req_last_bin,
   input logic                             rsp_empty,
   input logic                             rsp_pop,
   input logic [tnspp_pkg::PEAK_BIN_W-1:0] rsp_peak_bin,
   input logic [tnspp_pkg::MAG_W-1:0]      rsp_peak_magnitude
);

   // reset leaves no pick waiting
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   // the last bin starts a search, which blocks further bins
   a_last_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full && req_last_bin) |=> req_full)
      else $error("input still open after last bin");

   // a pick with no magnitude reports bin zero
   a_zero_pick: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_peak_magnitude == '0)) |-> (rsp_peak_bin == '0))
      else $error("empty pick with non-zero bin");

   // a waiting pick stays until popped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_peak_bin)))
      else $error("waiting pick lost or changed");

endmodule

bind top_n_spectral_peak_picker_core tnspp_checker u_checker (.*);
